// ----- src/tes_pkg.sv -----
package tes_pkg;

    localparam int MaxEvents  = 4;
    localparam int NumWords   = 4;
    localparam int TimeW      = 20;
    localparam int ProgW      = 17;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 40;
    localparam int EvIdxW     = 3;

    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
    localparam logic [ProgW-1:0] OneQ16  = 17'h10000;

    localparam logic [1:0] ActTick  = 2'd0;
    localparam logic [1:0] ActStart = 2'd1;
    localparam logic [1:0] ActStop  = 2'd2;
    localparam logic [1:0] ActRsvd  = 2'd3;

    localparam logic [CfgIdxW-1:0] RegCount = 3'd4;
    localparam logic [CfgIdxW-1:0] RegLoop  = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load_in;     // capture input item
        logic do_start;
        logic do_stop;
        logic walk_init;   // begin a walk: now = last + dt, end = 0, clear event
        logic wrap_init;   // begin second walk from 0 with leftover time
        logic ev_step;     // evaluate event at index, advance end
        logic div_start;
        logic div_step;
        logic set_done;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       run;
        logic       idx_end;    // index reached limit
        logic       hit;        // event at index overlaps window
        logic       hit_dur_nz;
        logic       div_last;
        logic       no_event;   // current event 0
        logic       past_end;   // last > end
        logic       loop_en;
    } t_sts;

endpackage

// ----- src/tes_ctrl.sv -----
module tes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tes_pkg::t_sts    i_sts,
    output tes_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_second, n_second;
    logic       r_out_valid, n_out_valid;

    // a new item may enter while the last result still waits
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_second = 1'b0;
                if (i_sts.action == tes_pkg::ActStart) begin
                    o_cmd.do_start = !i_sts.run;
                    n_state = S_FIN;
                end else if (i_sts.action == tes_pkg::ActStop) begin
                    o_cmd.do_stop = 1'b1;
                    n_state = S_FIN;
                end else if (i_sts.action == tes_pkg::ActTick && i_sts.run) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK: begin
                if (i_sts.idx_end) begin
                    n_state = r_second ? S_FIN : S_CHECK;
                end else begin
                    o_cmd.ev_step = 1'b1;
                    if (i_sts.hit) begin
                        if (i_sts.hit_dur_nz) begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end else begin
                            n_state = r_second ? S_FIN : S_CHECK;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = r_second ? S_FIN : S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.no_event && i_sts.past_end) begin
                    if (i_sts.loop_en) begin
                        o_cmd.wrap_init = 1'b1;
                        n_second = 1'b1;
                        n_state = S_WALK;
                    end else begin
                        o_cmd.set_done = 1'b1;
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the result register to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/tes_dp.sv -----
module tes_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tes_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [tes_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [15:0]                   i_dt,
    input  logic [7:0]                    i_query_id,
    input  tes_pkg::t_cmd                 i_cmd,
    output tes_pkg::t_sts                 o_sts,
    output logic                          o_running_now,
    output logic                          o_done_now,
    output logic [7:0]                    o_active_id,
    output logic [tes_pkg::ProgW-1:0]     o_progress,
    output logic                          o_is_on
);

    localparam int EndW = tes_pkg::TimeW + 1;
    localparam int DivW = tes_pkg::TimeW + 16;

    logic [tes_pkg::CfgDataW-1:0] r_word [tes_pkg::NumWords];
    logic [2:0]  r_count;
    logic        r_loop;

    logic [1:0]  r_action;
    logic [15:0] r_dt;
    logic [7:0]  r_query;

    logic        r_run, r_done;
    logic [tes_pkg::TimeW-1:0] r_time, r_last;
    logic [7:0]  r_event;
    logic [tes_pkg::ProgW-1:0] r_prog;

    logic [tes_pkg::EvIdxW-1:0] r_idx;
    logic [EndW-1:0] r_end;

    // restoring divider, one quotient bit a cycle
    logic [DivW-1:0] r_num;
    logic [16:0]     r_rem;
    logic [15:0]     r_den;
    logic [5:0]      r_dcnt;

    logic [tes_pkg::CfgDataW-1:0] w_word;
    logic [15:0] w_delay, w_dur;
    logic [7:0]  w_id;
    logic [EndW:0] w_start, w_evend;
    logic [2:0]  w_limit;
    logic [EndW:0] w_sum;
    logic [tes_pkg::TimeW-1:0] w_now;
    logic [EndW:0] w_left;
    logic [17:0] w_trial;
    logic [16:0] w_rem_sh;
    logic [DivW-1:0] w_q_sat_src;

    assign w_limit = (r_count > 3'(tes_pkg::MaxEvents)) ? 3'(tes_pkg::MaxEvents) : r_count;
    assign w_word  = (r_idx < 3'(tes_pkg::NumWords)) ? r_word[r_idx[1:0]] : '0;
    assign w_delay = w_word[15:0];
    assign w_dur   = w_word[31:16];
    assign w_id    = w_word[39:32];
    assign w_start = {1'b0, r_end} + (EndW+1)'(w_delay);
    assign w_evend = w_start + (EndW+1)'(w_dur);

    assign w_sum = (EndW+1)'(r_time) + (EndW+1)'(r_dt);
    assign w_now = (w_sum > (EndW+1)'(tes_pkg::TimeMax)) ? tes_pkg::TimeMax
                                                         : w_sum[tes_pkg::TimeW-1:0];
    // leftover: last - end + dt, end < last here
    assign w_left = (EndW+1)'(r_last) - (EndW+1)'(r_end) + (EndW+1)'(r_dt);

    assign w_rem_sh = {r_rem[15:0], r_num[DivW-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {2'b0, r_den};
    assign w_q_sat_src = r_num;

    assign o_sts.action     = r_action;
    assign o_sts.run        = r_run;
    assign o_sts.idx_end    = ({1'b0, r_idx} >= {1'b0, w_limit});
    assign o_sts.hit        = (w_start <= (EndW+1)'(r_time))
                              && (w_evend >= (EndW+1)'(r_last));
    assign o_sts.hit_dur_nz = (w_dur != 16'd0);
    assign o_sts.div_last   = (r_dcnt == 6'd1);
    assign o_sts.no_event   = (r_event == 8'd0);
    assign o_sts.past_end   = ((EndW)'(r_last) > r_end);
    assign o_sts.loop_en    = r_loop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word[0] <= '0; r_word[1] <= '0; r_word[2] <= '0; r_word[3] <= '0;
            r_count <= '0;
            r_loop  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < 3'(tes_pkg::NumWords)) begin
                r_word[i_cfg_idx[1:0]] <= i_cfg_data;
            end else if (i_cfg_idx == tes_pkg::RegCount) begin
                r_count <= i_cfg_data[2:0];
            end else if (i_cfg_idx == tes_pkg::RegLoop) begin
                r_loop <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_dt     <= i_dt;
            r_query  <= i_query_id;
        end
        if (i_cmd.div_start) begin
            r_num  <= DivW'({r_time - w_start[tes_pkg::TimeW-1:0], 16'd0});
            r_den  <= w_dur;
            r_rem  <= '0;
            r_dcnt <= 6'(DivW);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (!w_trial[17]) begin
                r_rem <= w_trial[16:0];
                r_num <= {r_num[DivW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_num <= {r_num[DivW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_time  <= '0;
            r_last  <= '0;
            r_event <= '0;
            r_prog  <= '0;
            r_idx   <= '0;
            r_end   <= '0;
        end else begin
            if (i_cmd.do_start || i_cmd.do_stop) begin
                r_run   <= i_cmd.do_start;
                r_done  <= 1'b0;
                r_time  <= '0;
                r_event <= '0;
                r_prog  <= '0;
            end
            if (i_cmd.walk_init) begin
                r_last  <= r_time;
                r_time  <= w_now;
                r_event <= '0;
                r_prog  <= '0;
                r_idx   <= '0;
                r_end   <= '0;
            end
            if (i_cmd.wrap_init) begin
                r_last  <= '0;
                r_time  <= (w_left > (EndW+1)'(tes_pkg::TimeMax)) ? tes_pkg::TimeMax
                                                : w_left[tes_pkg::TimeW-1:0];
                r_event <= '0;
                r_prog  <= '0;
                r_idx   <= '0;
                r_end   <= '0;
            end
            if (i_cmd.ev_step) begin
                r_idx <= r_idx + 3'd1;
                r_end <= w_evend[EndW-1:0];
                if (o_sts.hit) begin
                    r_event <= w_id;
                end
            end
            if (i_cmd.div_step && o_sts.div_last) begin
                // last quotient bit lands here
                if ({w_q_sat_src[DivW-2:0], !w_trial[17]} > DivW'(tes_pkg::OneQ16)) begin
                    r_prog <= tes_pkg::OneQ16;
                end else begin
                    r_prog <= tes_pkg::ProgW'({w_q_sat_src[DivW-2:0], !w_trial[17]});
                end
            end
            if (i_cmd.set_done) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_running_now <= r_run;
            o_done_now    <= r_done;
            o_active_id   <= r_event;
            o_progress    <= r_prog;
            o_is_on       <= r_run && (r_event != 8'd0) && (r_event == r_query);
        end
    end

endmodule

// ----- src/timed_event_sequencer_core.sv -----
// channel   dir  tdata fields (low bit up)                          tuser
// s_axis    in   dt[15:0], query_id[23:16]                          action[1:0]
// m_axis    out  running_now[0], done_now[1], active_id[9:2],
//                progress[26:10], is_on[27]
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (event words, count, loop)
//
// a start or stop item is decoded and its result loaded; a tick walks up to four
// events in order and stops at the first hit, whose nonzero duration starts a serial
// divide; after the first walk a check may start a second walk from zero or set done
// sync active-low reset clears flags, time and config registers
// the next item is taken while a result waits; a stalled output holds the
// controller before loading the result register

module timed_event_sequencer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tes_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tes_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // dt, query_id
    input  logic [1:0]                   s_axis_tuser,  // action
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata   // running_now, done_now,
                                                        // active_id, progress, is_on
);

    tes_pkg::t_cmd w_cmd;
    tes_pkg::t_sts w_sts;
    logic        w_run, w_done, w_on;
    logic [7:0]  w_id;
    logic [tes_pkg::ProgW-1:0] w_prog;

    tes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tes_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (s_axis_tuser),
        .i_dt          (s_axis_tdata[15:0]),
        .i_query_id    (s_axis_tdata[23:16]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_running_now (w_run),
        .o_done_now    (w_done),
        .o_active_id   (w_id),
        .o_progress    (w_prog),
        .o_is_on       (w_on)
    );

    assign m_axis_tdata = {4'd0, w_on, w_prog, w_id, w_done, w_run};

endmodule

// ----- tb/timed_event_sequencer_checker.sv -----
module timed_event_sequencer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        is_on;
        logic [16:0] progress;
        logic [7:0]  active_id;
        logic        done_now;
        logic        running_now;
    } t_status;

    logic [39:0] ev_word [4];
    logic [2:0]  ev_count;
    logic        loop_en;
    logic        run_q, done_q;
    logic [19:0] time_q;
    logic [7:0]  event_q;
    logic [16:0] prog_q;
    t_status     status_q[$];

    // one pass over the events, returns the end of the last one looked at
    function automatic logic [31:0] scan_events(logic [31:0] last, logic [31:0] dt);
        logic [31:0] now, fin, start, delay, dur, lim;
        logic [63:0] q;
        fin = 0;
        now = last + dt;
        if (now > 32'hFFFFF) now = 32'hFFFFF;
        lim = (ev_count > 3'd4) ? 32'd4 : 32'(ev_count);
        time_q = now[19:0];
        event_q = '0;
        prog_q = '0;
        for (int i = 0; i < lim; i++) begin
            delay = 32'(ev_word[i][15:0]);
            dur = 32'(ev_word[i][31:16]);
            start = fin + delay;
            fin = start + dur;
            if (start <= now && fin >= last) begin
                if (dur > 0) begin
                    q = {32'd0, now - start} << 16;
                    q = q / {32'd0, dur};
                    prog_q = (q > 64'd65536) ? 17'h10000 : q[16:0];
                end
                event_q = ev_word[i][39:32];
                return fin;
            end
        end
        return fin;
    endfunction

    function automatic t_status advance(logic [1:0] act, logic [15:0] dt, logic [7:0] qid);
        logic [31:0] last, fin, left;
        t_status r;
        if (act == tes_pkg::ActStart) begin
            if (!run_q) begin
                run_q = 1; done_q = 0; time_q = '0; event_q = '0; prog_q = '0;
            end
        end else if (act == tes_pkg::ActStop) begin
            run_q = 0; done_q = 0; time_q = '0; event_q = '0; prog_q = '0;
        end else if (act == tes_pkg::ActTick && run_q) begin
            last = 32'(time_q);
            fin = scan_events(last, 32'(dt));
            if (event_q == 0 && last > fin) begin
                if (loop_en) begin
                    left = last - fin + 32'(dt);
                    if (left > 32'hFFFFF) left = 32'hFFFFF;
                    void'(scan_events(32'd0, left));
                end else begin
                    run_q = 0; done_q = 1;
                end
            end
        end
        r.running_now = run_q;
        r.done_now = done_q;
        r.active_id = event_q;
        r.progress = prog_q;
        r.is_on = run_q && event_q != 0 && event_q == qid;
        return r;
    endfunction

    assign o_pending = status_q.size();

    always @(posedge i_clk) begin
        t_status got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) ev_word[i] <= '0;
            ev_count <= '0; loop_en <= 0;
            run_q = 0; done_q = 0; time_q = '0; event_q = '0; prog_q = '0;
            status_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < 3'(tes_pkg::NumWords)) ev_word[i_cfg_idx[1:0]] <= i_cfg_data;
                else if (i_cfg_idx == tes_pkg::RegCount) ev_count <= i_cfg_data[2:0];
                else if (i_cfg_idx == tes_pkg::RegLoop) loop_en <= i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(advance(i_in_user, i_in_data[15:0], i_in_data[23:16]));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[27:0];
                if (status_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected item %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = status_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: run %b/%b done %b/%b id %0d/%0d prog %0d/%0d on %b/%b",
                                want.running_now, got.running_now, want.done_now, got.done_now,
                                want.active_id, got.active_id, want.progress, got.progress,
                                want.is_on, got.is_on);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/timed_event_sequencer_core_tb.sv -----
module timed_event_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [39:0] i_cfg_data;
    logic        s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count, pending, idle_cycles;
    bit          draining;

    timed_event_sequencer_core DUT (.*);

    timed_event_sequencer_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stalls a random number of cycles before each item
    initial begin
        int w;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            w = $urandom_range(0, 15);
            if (!draining && w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic send_item(logic [1:0] act, logic [15:0] dt, logic [7:0] qid, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 15) : 0;
        if (w > 0) begin
            s_axis_tvalid <= 0;
            repeat (w) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {qid, dt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random windows up to span, so ticks land in and past events
    task automatic setup_events(int span);
        for (int i = 0; i < 4; i++)
            write_reg(3'(i), {8'($urandom_range(0, 255)), 16'($urandom_range(0, span)),
                              16'($urandom_range(0, span))});
        write_reg(tes_pkg::RegCount, 40'($urandom_range(0, 7)));
        write_reg(tes_pkg::RegLoop, 40'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [15:0] dt;
        logic [7:0]  qid;
        int          span;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; draining = 0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: zero events, then extremes
        send_item(tes_pkg::ActTick, 16'd5, 8'd0, 1'b0);
        send_item(tes_pkg::ActStart, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActTick, 16'hFFFF, 8'd0, 1'b0);
        send_item(tes_pkg::ActStop, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActRsvd, 16'h1234, 8'hFF, 1'b0);
        wait_quiet();
        write_reg(3'd0, {8'd7, 16'd0, 16'd10});
        write_reg(3'd1, {8'd0, 16'd20, 16'd5});
        write_reg(3'd2, {8'hFF, 16'hFFFF, 16'hFFFF});
        write_reg(3'd3, {8'd9, 16'd100, 16'd0});
        write_reg(tes_pkg::RegCount, 40'd7);
        write_reg(tes_pkg::RegLoop, 40'd1);
        send_item(tes_pkg::ActStart, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActStart, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActTick, 16'd10, 8'd7, 1'b0);
        send_item(tes_pkg::ActTick, 16'd10, 8'd0, 1'b0);
        send_item(tes_pkg::ActTick, 16'd30, 8'hFF, 1'b0);
        send_item(tes_pkg::ActTick, 16'hFFFF, 8'hFF, 1'b0);
        for (int k = 0; k < 20; k++) send_item(tes_pkg::ActTick, 16'hFFFF, 8'hFF, 1'b0);
        wait_quiet();
        write_reg(tes_pkg::RegLoop, 40'd0);
        write_reg(tes_pkg::RegCount, 40'd1);
        send_item(tes_pkg::ActStop, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActStart, 16'd0, 8'd0, 1'b0);
        send_item(tes_pkg::ActTick, 16'd100, 8'd7, 1'b0);
        send_item(tes_pkg::ActTick, 16'd1, 8'd7, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < 14; ph++) begin
            span = (ph % 3 == 0) ? 65535 : 40;
            setup_events(span);
            for (int k = 0; k < 110; k++) begin
                case ($urandom_range(0, 19))
                    0: send_item(tes_pkg::ActStart, 16'($urandom), 8'($urandom), 1'(ph % 2));
                    1: send_item(tes_pkg::ActStop, 16'($urandom), 8'($urandom), 1'(ph % 2));
                    2: send_item(tes_pkg::ActRsvd, 16'($urandom), 8'($urandom), 1'(ph % 2));
                    default: begin
                        dt = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, span));
                        qid = ($urandom_range(0, 1)) ? 8'($urandom) : 8'(DUT.m_axis_tdata[9:2]);
                        send_item(tes_pkg::ActTick, dt, qid, 1'(ph % 2));
                        if ($urandom_range(0, 6) == 0)
                            send_item(tes_pkg::ActStart, 16'd0, 8'd0, 1'(ph % 2));
                    end
                endcase
            end
            wait_quiet();
        end

        draining = 1;
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
src/tes_pkg.sv
src/tes_ctrl.sv
src/tes_dp.sv
src/timed_event_sequencer_core.sv
tb/timed_event_sequencer_checker.sv
tb/timed_event_sequencer_core_tb.sv
